FILE: sv/lci_pkg.sv
// Shared constants for the line and circle intersection block.
`default_nettype none

package lci_pkg;

  localparam int HIT_BITS  = 23;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [HIT_BITS-1:0] HIT_MAX = {1'b0, {(HIT_BITS-1){1'b1}}};
  localparam logic signed [HIT_BITS-1:0] HIT_MIN = {1'b1, {(HIT_BITS-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd2;

endpackage

`default_nettype wire

FILE: sv/line_circle_intersection.sv
// Line and circle intersection pipeline: top level with config, point expansion and output.
// Throughput: one line per cycle while the output is not stalled and the line gives at most one point;
// a line with two points holds the input while its first point is formed, then its second point follows.
// The square root and divider run one bit per pipeline stage; a stalled output freezes all stages.
// Reset clears all valid bits and the circle registers; the block accepts a line right away.
`default_nettype none

module line_circle_intersection import lci_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 6
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire  signed [COORD_BITS-1:0]  start_x_i,
  input  wire  signed [COORD_BITS-1:0]  start_y_i,
  input  wire  signed [COORD_BITS-1:0]  end_x_i,
  input  wire  signed [COORD_BITS-1:0]  end_y_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic signed [HIT_BITS-1:0]    hit_x_o,
  output logic signed [HIT_BITS-1:0]    hit_y_o,
  output logic                          saturated_o,
  output logic                          last_point_o,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]          cfg_index_i,
  input  wire  [COORD_BITS-1:0]         cfg_data_i
);

  localparam int CB  = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int DW1 = CB + 1;
  localparam int KW  = 2 * CB + 2;
  localparam int AW  = 2 * CB + 1;
  localparam int RW  = 4 * CB + 1;
  localparam int DW  = RW + 2 * F;
  localparam int SW  = (DW + 1) / 2;
  localparam int PKW = 3 * CB + 3;
  localparam int QSW = 3 * CB + F + 3;
  localparam int NW  = 3 * CB + F + 4;
  localparam int MW  = NW + 2;
  localparam int DVW = AW + 1;
  localparam int QW  = CB + F + 2;
  localparam int VW  = CB + F + 4;
  localparam int CW  = ((VW > HIT_BITS) ? VW : HIT_BITS) + 1;
  localparam int PW  = 2 * DW1 + KW + AW + 2;

  // Configuration registers
  logic signed [CB-1:0] cx_q, cy_q;
  logic        [CB-1:0] rad_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      rad_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CENTER_X: cx_q  <= cfg_data_i;
        CFG_CENTER_Y: cy_q  <= cfg_data_i;
        CFG_RADIUS:   rad_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en, front_en, hold;

  // Front stages
  logic                  f_valid, f_hit, f_two;
  logic signed [DW1-1:0] f_dx, f_dy;
  logic signed [KW-1:0]  f_k;
  logic        [AW-1:0]  f_a;
  logic        [RW-1:0]  f_r;

  lci_front #(.CB(CB)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (front_en),
    .valid_i    (in_valid_i),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .center_x_i (cx_q),
    .center_y_i (cy_q),
    .radius_i   (rad_q),
    .valid_o    (f_valid),
    .dx_o       (f_dx),
    .dy_o       (f_dy),
    .k_o        (f_k),
    .a_o        (f_a),
    .r_o        (f_r),
    .hit_o      (f_hit),
    .two_o      (f_two)
  );

  // Square root of the discriminant scaled by 2^(2*FRAC_BITS)
  logic          l_valid;
  logic [SW-1:0] l_root;
  logic [PW-1:0] l_pass;

  lci_sqrt #(.DW(DW), .PW(PW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (front_en),
    .valid_i (f_valid),
    .val_i   (DW'(f_r) << (2 * F)),
    .pass_i  ({f_dx, f_dy, f_k, f_a, f_two, f_hit}),
    .valid_o (l_valid),
    .root_o  (l_root),
    .pass_o  (l_pass)
  );

  logic signed [DW1-1:0] l_dx, l_dy;
  logic signed [KW-1:0]  l_k;
  logic        [AW-1:0]  l_a;
  logic                  l_two, l_hit;

  assign {l_dx, l_dy, l_k, l_a, l_two, l_hit} = l_pass;

  // A line with two points holds the front while its first point is formed; the second follows from the same line.
  logic ph_q;

  assign en         = !(out_valid_o && out_stall_i);
  assign hold       = l_valid && l_two && !ph_q;
  assign front_en   = en && !hold;
  assign in_stall_o = !front_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= 1'b0;
    end else if (en && l_valid && l_two) begin
      ph_q <= !ph_q;
    end
  end

  // Point stage 1: products
  logic                  p1_v_q, p1_last_q;
  logic signed [PKW-1:0] pkx_q, pky_q;
  logic signed [QSW-1:0] qsx_q, qsy_q;
  logic        [AW-1:0]  p1_a_q;
  logic signed [DW1-1:0] neg_dy, qx, qy;
  logic signed [SW:0]    root_s;

  assign neg_dy = -l_dy;
  assign qx     = ph_q ? -l_dx : l_dx;
  assign qy     = ph_q ? -l_dy : l_dy;
  assign root_s = $signed({1'b0, l_root});

  // Point stage 2: rounded numerator, split into sign and magnitude
  logic                  p2_v_q, p2_last_q;
  logic        [MW-1:0]  ux_q, uy_q;
  logic                  negx_q, negy_q;
  logic        [DVW-1:0] d2_q;
  logic signed [NW-1:0]  nx, ny;
  logic signed [MW-1:0]  mx, my;

  assign nx = (NW'(pkx_q) <<< F) + NW'(qsx_q);
  assign ny = (NW'(pky_q) <<< F) + NW'(qsy_q);
  assign mx = (MW'(nx) <<< 1) + $signed(MW'(p1_a_q));
  assign my = (MW'(ny) <<< 1) + $signed(MW'(p1_a_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= l_valid && l_hit;
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pkx_q     <= PKW'(neg_dy) * PKW'(l_k);
      pky_q     <= PKW'(l_dx) * PKW'(l_k);
      qsx_q     <= QSW'(qx) * QSW'(root_s);
      qsy_q     <= QSW'(qy) * QSW'(root_s);
      p1_a_q    <= l_a;
      p1_last_q <= !l_two || ph_q;

      negx_q    <= mx[MW-1];
      negy_q    <= my[MW-1];
      ux_q      <= mx[MW-1] ? ~mx : mx;
      uy_q      <= my[MW-1] ? ~my : my;
      d2_q      <= {p1_a_q, 1'b0};
      p2_last_q <= p1_last_q;
    end
  end

  // Division by 2A
  logic                d_valid, d_last;
  logic signed [QW:0]  offx, offy;

  lci_div #(.MW(MW), .DVW(DVW), .QW(QW), .PW(1)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p2_v_q),
    .ux_i    (ux_q),
    .uy_i    (uy_q),
    .negx_i  (negx_q),
    .negy_i  (negy_q),
    .d_i     (d2_q),
    .pass_i  (p2_last_q),
    .valid_o (d_valid),
    .offx_o  (offx),
    .offy_o  (offy),
    .pass_o  (d_last)
  );

  // Add the center and clamp to the output range
  logic signed [VW-1:0] vx, vy;
  logic signed [CW-1:0] wx, wy, hx, hy, hi_lim, lo_lim;
  logic                 satx, saty;

  assign hi_lim = CW'(HIT_MAX);
  assign lo_lim = CW'(HIT_MIN);
  assign vx     = (VW'(cx_q) <<< F) + VW'(offx);
  assign vy     = (VW'(cy_q) <<< F) + VW'(offy);
  assign wx     = CW'(vx);
  assign wy     = CW'(vy);
  assign satx   = (wx > hi_lim) || (wx < lo_lim);
  assign saty   = (wy > hi_lim) || (wy < lo_lim);
  assign hx     = (wx > hi_lim) ? hi_lim : ((wx < lo_lim) ? lo_lim : wx);
  assign hy     = (wy > hi_lim) ? hi_lim : ((wy < lo_lim) ? lo_lim : wy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_x_o      <= hx[HIT_BITS-1:0];
      hit_y_o      <= hy[HIT_BITS-1:0];
      saturated_o  <= satx || saty;
      last_point_o <= d_last;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lci_front.sv
// Front stages: direction, offsets, A, K and the quarter discriminant.
`default_nettype none

module lci_front #(
  parameter int CB = 12
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     en_i,
  input  wire                     valid_i,
  input  wire  signed [CB-1:0]    start_x_i,
  input  wire  signed [CB-1:0]    start_y_i,
  input  wire  signed [CB-1:0]    end_x_i,
  input  wire  signed [CB-1:0]    end_y_i,
  input  wire  signed [CB-1:0]    center_x_i,
  input  wire  signed [CB-1:0]    center_y_i,
  input  wire         [CB-1:0]    radius_i,
  output logic                    valid_o,
  output logic signed [CB:0]      dx_o,
  output logic signed [CB:0]      dy_o,
  output logic signed [2*CB+1:0]  k_o,
  output logic        [2*CB:0]    a_o,
  output logic        [4*CB:0]    r_o,
  output logic                    hit_o,
  output logic                    two_o
);

  localparam int DW1 = CB + 1;
  localparam int SQW = 2 * CB + 2;
  localparam int AW  = 2 * CB + 1;
  localparam int KW  = 2 * CB + 2;
  localparam int RRW = 2 * CB;
  localparam int RW  = 4 * CB + 1;
  localparam int KKW = 4 * CB + 3;
  localparam int DFW = 4 * CB + 3;

  // Stage 1
  logic                  v1_q;
  logic signed [DW1-1:0] dx1_q, dy1_q, rx1_q, ry1_q;
  // Stage 2
  logic                  v2_q;
  logic signed [SQW-1:0] xx2_q, yy2_q, xr2_q, yr2_q;
  logic        [RRW-1:0] rr2_q;
  logic signed [DW1-1:0] dx2_q, dy2_q;
  // Stage 3
  logic                  v3_q;
  logic        [AW-1:0]  a3_q;
  logic signed [KW-1:0]  k3_q;
  logic        [RRW-1:0] rr3_q;
  logic signed [DW1-1:0] dx3_q, dy3_q;
  // Stage 4
  logic                  v4_q;
  logic        [RW-1:0]  ar2_q;
  logic        [KKW-2:0] kk4_q;
  logic        [AW-1:0]  a4_q;
  logic signed [KW-1:0]  k4_q;
  logic signed [DW1-1:0] dx4_q, dy4_q;
  // Stage 5
  logic                  v5_q;

  logic signed [SQW-1:0] asum;
  logic signed [KKW-1:0] kk_full;
  logic signed [DFW-1:0] disc;

  assign asum    = xx2_q + yy2_q;
  assign kk_full = KKW'(k3_q) * KKW'(k3_q);
  assign disc    = $signed({2'b00, ar2_q}) - $signed({1'b0, kk4_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx1_q <= DW1'(end_x_i) - DW1'(start_x_i);
      dy1_q <= DW1'(end_y_i) - DW1'(start_y_i);
      rx1_q <= DW1'(start_x_i) - DW1'(center_x_i);
      ry1_q <= DW1'(start_y_i) - DW1'(center_y_i);

      xx2_q <= SQW'(dx1_q) * SQW'(dx1_q);
      yy2_q <= SQW'(dy1_q) * SQW'(dy1_q);
      xr2_q <= SQW'(dx1_q) * SQW'(ry1_q);
      yr2_q <= SQW'(dy1_q) * SQW'(rx1_q);
      rr2_q <= RRW'(radius_i) * RRW'(radius_i);
      dx2_q <= dx1_q;
      dy2_q <= dy1_q;

      a3_q  <= asum[AW-1:0];
      k3_q  <= xr2_q - yr2_q;
      rr3_q <= rr2_q;
      dx3_q <= dx2_q;
      dy3_q <= dy2_q;

      ar2_q <= RW'(a3_q) * RW'(rr3_q);
      kk4_q <= kk_full[KKW-2:0];
      a4_q  <= a3_q;
      k4_q  <= k3_q;
      dx4_q <= dx3_q;
      dy4_q <= dy3_q;

      // A negative discriminant or a degenerate line gives no point.
      r_o   <= disc[RW-1:0];
      hit_o <= (a4_q != '0) && !disc[DFW-1];
      two_o <= (a4_q != '0) && !disc[DFW-1] && (disc != '0);
      a_o   <= a4_q;
      k_o   <= k4_q;
      dx_o  <= dx4_q;
      dy_o  <= dy4_q;
    end
  end

  assign valid_o = v5_q;

endmodule

`default_nettype wire

FILE: sv/lci_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module lci_sqrt #(
  parameter int DW = 61,
  parameter int PW = 8
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  wire                    valid_i,
  input  wire  [DW-1:0]          val_i,
  input  wire  [PW-1:0]          pass_i,
  output logic                   valid_o,
  output logic [(DW+1)/2-1:0]    root_o,
  output logic [PW-1:0]          pass_o
);

  localparam int SW = (DW + 1) / 2;
  localparam int TW = 2 * SW + 1;

  logic          vld_q  [SW];
  logic [TW-1:0] rem_q  [SW];
  logic [SW-1:0] root_q [SW];
  logic [PW-1:0] pass_q [SW];

  for (genvar j = 0; j < SW; j++) begin : g_stage
    localparam int B = SW - 1 - j;
    logic          v_in;
    logic [TW-1:0] rem_in, trial, rem_d;
    logic [SW-1:0] root_in, root_d;
    logic [PW-1:0] p_in;
    logic          ge;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = TW'(val_i);
      assign root_in = '0;
      assign p_in    = pass_i;
    end else begin : g_next
      assign v_in    = vld_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign p_in    = pass_q[j-1];
    end

    // The remainder holds value minus root squared; try setting bit B.
    assign trial  = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
    assign ge     = rem_in >= trial;
    assign rem_d  = ge ? rem_in - trial : rem_in;
    assign root_d = ge ? (root_in | (SW'(1) << B)) : root_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        root_q[j] <= root_d;
        pass_q[j] <= p_in;
      end
    end
  end

  assign valid_o = vld_q[SW-1];
  assign root_o  = root_q[SW-1];
  assign pass_o  = pass_q[SW-1];

endmodule

`default_nettype wire

FILE: sv/lci_div.sv
// Pipelined two-lane floor division by a shared positive divisor.
`default_nettype none

module lci_div #(
  parameter int MW  = 48,
  parameter int DVW = 26,
  parameter int QW  = 20,
  parameter int PW  = 1
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  en_i,
  input  wire                  valid_i,
  input  wire  [MW-1:0]        ux_i,
  input  wire  [MW-1:0]        uy_i,
  input  wire                  negx_i,
  input  wire                  negy_i,
  input  wire  [DVW-1:0]       d_i,
  input  wire  [PW-1:0]        pass_i,
  output logic                 valid_o,
  output logic signed [QW:0]   offx_o,
  output logic signed [QW:0]   offy_o,
  output logic [PW-1:0]        pass_o
);

  logic [MW-1:0]  u_lane   [2];
  logic           neg_lane [2];

  logic           vld_q  [QW];
  logic [DVW-1:0] d_q    [QW];
  logic [PW-1:0]  pass_q [QW];
  logic [DVW-1:0] rem_q  [QW][2];
  logic [QW-1:0]  u_q    [QW][2];
  logic [QW-1:0]  q_q    [QW][2];
  logic           neg_q  [QW][2];

  assign u_lane[0]   = ux_i;
  assign u_lane[1]   = uy_i;
  assign neg_lane[0] = negx_i;
  assign neg_lane[1] = negy_i;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int B = QW - 1 - j;
    logic           v_in;
    logic [DVW-1:0] d_in;
    logic [PW-1:0]  p_in;

    if (j == 0) begin : g_first
      assign v_in = valid_i;
      assign d_in = d_i;
      assign p_in = pass_i;
    end else begin : g_next
      assign v_in = vld_q[j-1];
      assign d_in = d_q[j-1];
      assign p_in = pass_q[j-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DVW-1:0] r_in, r_d;
      logic [QW-1:0]  u_in, q_in, q_d;
      logic           n_in;
      logic [DVW:0]   r2;
      logic           ge;

      if (j == 0) begin : g_first
        // The quotient fits QW bits, so the bits above them are below the divisor.
        assign r_in = DVW'(u_lane[l] >> QW);
        assign u_in = u_lane[l][QW-1:0];
        assign q_in = '0;
        assign n_in = neg_lane[l];
      end else begin : g_next
        assign r_in = rem_q[j-1][l];
        assign u_in = u_q[j-1][l];
        assign q_in = q_q[j-1][l];
        assign n_in = neg_q[j-1][l];
      end

      assign r2  = {r_in, u_in[B]};
      assign ge  = r2 >= {1'b0, d_in};
      assign r_d = ge ? DVW'(r2 - {1'b0, d_in}) : r2[DVW-1:0];
      assign q_d = ge ? (q_in | (QW'(1) << B)) : q_in;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j][l] <= r_d;
          u_q[j][l]   <= u_in;
          q_q[j][l]   <= q_d;
          neg_q[j][l] <= n_in;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[j]    <= d_in;
        pass_q[j] <= p_in;
      end
    end
  end

  // A negative dividend m was divided as ~m; floor(m/d) is then ~quotient.
  assign offx_o  = neg_q[QW-1][0] ? $signed(~{1'b0, q_q[QW-1][0]})
                                  : $signed({1'b0, q_q[QW-1][0]});
  assign offy_o  = neg_q[QW-1][1] ? $signed(~{1'b0, q_q[QW-1][1]})
                                  : $signed({1'b0, q_q[QW-1][1]});
  assign valid_o = vld_q[QW-1];
  assign pass_o  = pass_q[QW-1];

endmodule

`default_nettype wire

FILE: sv/lci_checker.sv
// Port-level checks for the line and circle intersection block, bound to the top level.
`default_nettype none

module lci_checker import lci_pkg::*; (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        in_stall_o,
  input wire                        out_valid_o,
  input wire                        out_stall_i,
  input wire signed [HIT_BITS-1:0]  hit_x_o,
  input wire signed [HIT_BITS-1:0]  hit_y_o,
  input wire                        saturated_o
);

  // A stalled request stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled output request was dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(hit_x_o) && $stable(hit_y_o))
    else $error("stalled output payload changed");

  // Backpressure reaches the input while the output waits.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while output stalled");

  // A clipped point sits on a range limit.
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (hit_x_o == HIT_MAX) || (hit_x_o == HIT_MIN) ||
      (hit_y_o == HIT_MAX) || (hit_y_o == HIT_MIN))
    else $error("saturated point not at a range limit");

endmodule

bind line_circle_intersection lci_checker u_lci_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .hit_x_o     (hit_x_o),
  .hit_y_o     (hit_y_o),
  .saturated_o (saturated_o)
);

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the line and circle intersection block.
`default_nettype none

module tb_top;
  import lci_pkg::*;

  localparam int CW       = 12;
  localparam int FB       = 6;
  localparam int LATENCY  = 80;
  localparam int WD_LIMIT = 20000;
  localparam int N_PHASES = 7;
  localparam int PER_PHASE = 245;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [HIT_BITS-1:0] x;
    logic signed [HIT_BITS-1:0] y;
    logic                       sat;
    logic                       last;
  } hit_t;

  typedef struct {
    int sx, sy, ex, ey;
    int typed_n;   // -1: use the predictor; otherwise the typed number of points
    int hx, hy;    // typed single point, in fixed point
  } line_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CW-1:0] start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [HIT_BITS-1:0] hit_x_o, hit_y_o;
  logic saturated_o, last_point_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_CENTER_X;
  logic [CW-1:0] cfg_data_i = '0;

  line_circle_intersection u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Circle registers as the block should hold them.
  logic signed [CW-1:0] circ_cx = '0, circ_cy = '0;
  logic [CW-1:0]        circ_r = '0;

  hit_t expected_hits[$];
  int   errors = 0;
  int   lines_sent = 0;
  int   hits_seen = 0;
  int   idle_cycles = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic queue_hit(input hit_t h);
    expected_hits = {expected_hits, h};
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, cand;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (cand * cand <= v) res = cand;
    end
    return res;
  endfunction

  // One coordinate of a point: rounded offset from the center, then clamped.
  function automatic logic signed [HIT_BITS-1:0] hit_coord(input longint c, input longint p,
      input longint k, input longint q, input longint s, input longint a, inout logic sat);
    longint num, m, d2, off, v;
    num = p * k * (64'sd1 <<< FB) + q * s;
    m = 2 * num + a;
    d2 = 2 * a;
    if (m < 0) off = -((-m + d2 - 1) / d2);
    else off = m / d2;
    v = c * (64'sd1 <<< FB) + off;
    if (v > longint'(HIT_MAX)) begin
      v = HIT_MAX;
      sat = 1'b1;
    end
    if (v < longint'(HIT_MIN)) begin
      v = HIT_MIN;
      sat = 1'b1;
    end
    return v[HIT_BITS-1:0];
  endfunction

  task automatic predict_hits(input longint sx, input longint sy, input longint ex,
                              input longint ey);
    longint dx, dy, rx, ry, a, k, r, ar2, k2, s, sg;
    int n;
    hit_t h;
    dx = ex - sx;
    dy = ey - sy;
    rx = sx - circ_cx;
    ry = sy - circ_cy;
    a = dx * dx + dy * dy;
    k = dx * ry - dy * rx;
    r = longint'(circ_r);
    ar2 = a * r * r;
    k2 = k * k;
    if (a == 0 || ar2 < k2) return;
    n = (ar2 == k2) ? 1 : 2;
    s = (n == 1) ? 0 : longint'(int_sqrt((ar2 - k2) << (2 * FB)));
    for (int i = 0; i < n; i++) begin
      sg = (i == 0) ? 1 : -1;
      h.sat = 1'b0;
      h.x = hit_coord(circ_cx, -dy, k, sg * dx, s, a, h.sat);
      h.y = hit_coord(circ_cy, dx, k, sg * dy, s, a, h.sat);
      h.last = (i == n - 1);
      queue_hit(h);
    end
  endtask

  // Request sender: bursts of random length with random gaps.
  int burst_left = 0;

  task automatic send_line(input line_row_t row);
    hit_t h;
    int gap;
    in_valid_i <= 1'b1;
    start_x_i <= CW'(row.sx);
    start_y_i <= CW'(row.sy);
    end_x_i   <= CW'(row.ex);
    end_y_i   <= CW'(row.ey);
    do @(posedge clk_i); while (in_stall_o);
    lines_sent++;
    if (row.typed_n < 0) begin
      predict_hits(row.sx, row.sy, row.ex, row.ey);
    end else if (row.typed_n == 1) begin
      h.x = HIT_BITS'(row.hx);
      h.y = HIT_BITS'(row.hy);
      h.sat = 1'b0;
      h.last = 1'b1;
      queue_hit(h);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] data);
    in_valid_i <= 1'b0;
    // The pipeline may still carry lines that give no point.
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_CENTER_X: circ_cx = data;
      CFG_CENTER_Y: circ_cy = data;
      CFG_RADIUS:   circ_r  = data;
      default: ;
    endcase
  endtask

  task automatic set_circle(input int cx, input int cy, input int r);
    write_reg(CFG_CENTER_X, CW'(cx));
    write_reg(CFG_CENTER_Y, CW'(cy));
    write_reg(CFG_RADIUS, CW'(r));
  endtask

  function automatic int clamp_coord(input int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  // Most lines pass near the circle so that points are common.
  function automatic line_row_t random_line();
    line_row_t row;
    int r, span;
    r = int'(circ_r);
    row.typed_n = -1;
    row.hx = 0;
    row.hy = 0;
    if ($urandom_range(0, 9) < 7) begin
      row.sx = clamp_coord(int'(circ_cx) + $urandom_range(0, 2 * r) - r);
      row.sy = clamp_coord(int'(circ_cy) + $urandom_range(0, 2 * r) - r);
      span = ($urandom_range(0, 1) == 0) ? 16 : 4095;
      row.ex = clamp_coord(row.sx + $urandom_range(0, 2 * span) - span);
      row.ey = clamp_coord(row.sy + $urandom_range(0, 2 * span) - span);
      if ($urandom_range(0, 40) == 0) begin
        row.ex = row.sx;
        row.ey = row.sy;
      end
    end else begin
      row.sx = int'($signed(12'($urandom)));
      row.sy = int'($signed(12'($urandom)));
      row.ex = int'($signed(12'($urandom)));
      row.ey = int'($signed(12'($urandom)));
    end
    return row;
  endfunction

  // Directed lines for the reset circle (center 0, radius 0).
  line_row_t dot_rows[5] = '{
    '{0, 0, 0, 0, 0, 0, 0},
    '{-5, 0, 5, 0, 1, 0, 0},
    '{-2048, -2048, 2047, 2047, 1, 0, 0},
    '{10, 3, 20, 3, 0, 0, 0},
    '{2047, 2047, 2047, 2047, 0, 0, 0}
  };

  // Directed lines for center 0 and radius 100.
  line_row_t ring_rows[12] = '{
    '{-100, 100, 100, 100, 1, 0, 6400},
    '{-100, -100, 100, -100, 1, 0, -6400},
    '{2047, 2047, -2048, -2048, -1, 0, 0},
    '{-2048, 2047, 2047, -2048, -1, 0, 0},
    '{0, -100, 0, 100, -1, 0, 0},
    '{-2048, 0, 2047, 0, -1, 0, 0},
    '{-100, 99, 100, 99, -1, 0, 0},
    '{3, 5, 4, 5, -1, 0, 0},
    '{2047, -2048, 2047, -2048, 0, 0, 0},
    '{-2048, -2048, -2048, 2047, -1, 0, 0},
    '{0, 0, 1, 1, -1, 0, 0},
    '{100, 0, 100, 1, 1, 6400, 0}
  };

  // Result checker.
  always @(posedge clk_i) begin
    hit_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      hits_seen++;
      if (expected_hits.size() == 0) begin
        report_mismatch($sformatf("unexpected point (%0d, %0d)", hit_x_o, hit_y_o));
      end else begin
        e = expected_hits.pop_front();
        if (hit_x_o !== e.x) report_mismatch($sformatf("hit_x %0d, want %0d", hit_x_o, e.x));
        if (hit_y_o !== e.y) report_mismatch($sformatf("hit_y %0d, want %0d", hit_y_o, e.y));
        if (saturated_o !== e.sat)
          report_mismatch($sformatf("saturated %b, want %b", saturated_o, e.sat));
        if (last_point_o !== e.last)
          report_mismatch($sformatf("last_point %b, want %b", last_point_o, e.last));
      end
    end
  end

  // Receiver stall pattern: calm, light and heavy stretches.
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(posedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_cnt <= $urandom_range(16, 96);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 9) < 7);
    endcase
  end

  // Watchdog on cycles in which no handshake completes.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WD_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int cx, cy, r;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dot_rows[i]) send_line(dot_rows[i]);
    set_circle(0, 0, 100);
    write_reg(CFG_UNUSED, 12'hfff);  // no such register; must change nothing
    foreach (ring_rows[i]) send_line(ring_rows[i]);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin cx = -2048; cy = 2047; r = 4095; end
        1: begin cx = 2047; cy = -2048; r = 1; end
        2: begin cx = 0; cy = 0; r = 0; end
        default: begin
          cx = int'($signed(12'($urandom)));
          cy = int'($signed(12'($urandom)));
          r = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 4095))
                                          : int'($urandom_range(1, 300));
        end
      endcase
      set_circle(cx, cy, r);
      for (int i = 0; i < PER_PHASE; i++) send_line(random_line());
    end

    in_valid_i <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    $display("Sent %0d lines over %0d circle settings; %0d points checked.",
             lines_sent, N_PHASES + 2, hits_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
